[rtl/dlts_pkg.sv]
// ---------------------------------------------------------------------------
// Display line timing status package
// Shared constants, event codes and transaction layouts for the line timing
// and status unit.
// ---------------------------------------------------------------------------
package dlts_pkg;

	localparam int VISIBLE_LINES = 192;
	localparam int TOTAL_LINES   = 263;
	localparam int GX_LEAD       = 48;

	localparam int LINE_W   = 9;
	localparam int STATUS_W = 16;
	localparam int SKIP_W   = 4;
	localparam int SUM_W    = LINE_W + 1;

	// Status register bit positions.
	localparam int ST_VBLANK     = 0;
	localparam int ST_HBLANK     = 1;
	localparam int ST_MATCH      = 2;
	localparam int ST_VBLANK_IRQ = 3;
	localparam int ST_HBLANK_IRQ = 4;
	localparam int ST_MATCH_IRQ  = 5;
	localparam int ST_RO_W       = 3;
	localparam int ST_MATCH_LSB  = 8;

	typedef enum logic [1:0] {
		KIND_HBLANK = 2'd0,
		KIND_DRAW   = 2'd1,
		KIND_WRITE  = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t                kind;
		logic [STATUS_W-1:0]  write_value;
	} item_t;

	typedef struct packed {
		logic [4:0]          pad;
		logic                frame_start;
		logic                frame_post;
		logic                frame_finish;
		logic [LINE_W-1:0]   gx_line;
		logic                gx_valid;
		logic [LINE_W-1:0]   draw_line;
		logic                draw_valid;
		logic                irq_line_match;
		logic                irq_hblank;
		logic                irq_vblank;
		logic [LINE_W-1:0]   line;
		logic [STATUS_W-1:0] status;
	} result_t;

	localparam int RES_W = $bits(result_t);

endpackage

[rtl/display_line_timing_status_unit.sv]
// ---------------------------------------------------------------------------
// Display line timing status unit
// Line counter, status register, interrupts and frame-skip gating of
// scanline draw requests, driven by hblank, draw-start and write events.
//
// Channel   Direction  Content
// s_axis    in         tuser: kind; tdata: write_value
// m_axis    out        tdata: status, line, irqs, draw and 3D requests, frame marks
// cfg       in         cfg_data: frames_to_skip
//
// One event can be accepted in every clock cycle while m_axis_tready is high.
// Its result passes through the input register, then the result register,
// before it is offered on m_axis. While a result waits for m_axis_tready,
// one more event can be taken into the input register; after that s_axis_tready
// follows m_axis_tready. The asynchronous reset clears all counters, the status
// register and the skip setting. The configuration channel is always ready.
// ---------------------------------------------------------------------------
module display_line_timing_status_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [15:0]                  s_axis_tdata,  // [15:0] write_value
	input  logic [1:0]                   s_axis_tuser,  // [1:0] kind
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// [15:0] status, [24:16] line, [25] irq_vblank, [26] irq_hblank,
	// [27] irq_line_match, [28] draw_valid, [37:29] draw_line, [38] gx_valid,
	// [47:39] gx_line, [48] frame_finish, [49] frame_post, [50] frame_start
	output logic [dlts_pkg::RES_W-1:0]   m_axis_tdata,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [dlts_pkg::SKIP_W-1:0]  cfg_data
);

	dlts_pkg::item_t   in_item, item_s1;
	dlts_pkg::result_t result_s1, result_s2;
	logic              valid_s1, advance;

	assign in_item.kind        = dlts_pkg::kind_t'(s_axis_tuser);
	assign in_item.write_value = s_axis_tdata;
	assign cfg_ready           = 1'b1;
	assign m_axis_tdata        = result_s2;

	dlts_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	dlts_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_skip (cfg_data),
		.advance  (advance),
		.item     (item_s1),
		.result   (result_s1)
	);

	dlts_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.result_s1 (result_s1),
		.advance   (advance),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.result_s2 (result_s2)
	);

	a_line_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (result_s2.line < dlts_pkg::LINE_W'(dlts_pkg::TOTAL_LINES)))
		else $error("line counter out of range");

	a_draw_visible: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && result_s2.draw_valid)
		|-> (result_s2.draw_line < dlts_pkg::LINE_W'(dlts_pkg::VISIBLE_LINES)))
		else $error("draw request outside visible lines");

	a_post_with_finish: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (result_s2.frame_post == result_s2.frame_finish))
		else $error("frame post and frame finish disagree");

	a_irq_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(result_s2.irq_hblank
			&& (result_s2.irq_vblank || result_s2.irq_line_match)))
		else $error("hblank irq raised together with a draw-start irq");

endmodule

[rtl/dlts_in_stage.sv]
// ---------------------------------------------------------------------------
// Input stage
// Registers one incoming event transaction and releases it when the core
// hands it on to the result register.
// ---------------------------------------------------------------------------
module dlts_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  dlts_pkg::item_t in_item,
	input  logic            advance,
	output logic            valid_s1,
	output dlts_pkg::item_t item_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

[rtl/dlts_core.sv]
// ---------------------------------------------------------------------------
// Line timing core
// Holds the line counter, status register, frame-skip counter and skip
// setting, and works out the result of one event in a single pass.
// ---------------------------------------------------------------------------
module dlts_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [dlts_pkg::SKIP_W-1:0]      cfg_skip,
	input  logic                             advance,
	input  dlts_pkg::item_t                  item,
	output dlts_pkg::result_t                result
);

	logic [dlts_pkg::LINE_W-1:0]   line_q, line_n, line_inc;
	logic [dlts_pkg::STATUS_W-1:0] status_q, status_n;
	logic [dlts_pkg::SKIP_W-1:0]   skip_q, skip_n, frames_to_skip_q;
	logic [dlts_pkg::SUM_W-1:0]    lead_sum;
	logic                          skip_zero;

	assign lead_sum  = {1'b0, line_q} + dlts_pkg::SUM_W'(dlts_pkg::GX_LEAD);
	assign line_inc  = line_q + dlts_pkg::LINE_W'(1);
	assign skip_zero = (skip_q == '0);

	always_comb begin
		status_n = status_q;
		line_n   = line_q;
		skip_n   = skip_q;
		result   = '0;
		case (item.kind)
			dlts_pkg::KIND_HBLANK: begin
				status_n[dlts_pkg::ST_HBLANK] = 1'b1;
				if (skip_zero) begin
					if (line_q < dlts_pkg::LINE_W'(dlts_pkg::VISIBLE_LINES)) begin
						result.draw_valid = 1'b1;
						result.draw_line  = line_q;
					end
					if (lead_sum < dlts_pkg::SUM_W'(dlts_pkg::VISIBLE_LINES)) begin
						result.gx_valid = 1'b1;
						result.gx_line  = lead_sum[dlts_pkg::LINE_W-1:0];
					end else if (lead_sum >= dlts_pkg::SUM_W'(dlts_pkg::TOTAL_LINES)) begin
						result.gx_valid = 1'b1;
						result.gx_line  = dlts_pkg::LINE_W'(lead_sum
							- dlts_pkg::SUM_W'(dlts_pkg::TOTAL_LINES));
					end
				end
				result.irq_hblank = status_q[dlts_pkg::ST_HBLANK_IRQ];
			end
			dlts_pkg::KIND_DRAW: begin
				status_n[dlts_pkg::ST_HBLANK] = 1'b0;
				line_n = (line_inc >= dlts_pkg::LINE_W'(dlts_pkg::TOTAL_LINES)) ? '0 : line_inc;
				if (line_n == {1'b0, status_q[dlts_pkg::STATUS_W-1:dlts_pkg::ST_MATCH_LSB]})
				begin
					status_n[dlts_pkg::ST_MATCH] = 1'b1;
					result.irq_line_match = status_q[dlts_pkg::ST_MATCH_IRQ];
				end else begin
					status_n[dlts_pkg::ST_MATCH] = 1'b0;
				end
				result.frame_start = (line_n == '0);
				if (line_n == dlts_pkg::LINE_W'(dlts_pkg::VISIBLE_LINES)) begin
					status_n[dlts_pkg::ST_VBLANK] = 1'b1;
					result.frame_finish = skip_zero;
					result.frame_post   = skip_zero;
					result.irq_vblank   = status_q[dlts_pkg::ST_VBLANK_IRQ];
					skip_n = skip_zero ? frames_to_skip_q : skip_q - dlts_pkg::SKIP_W'(1);
				end else if (line_n == dlts_pkg::LINE_W'(dlts_pkg::TOTAL_LINES - 1)) begin
					status_n[dlts_pkg::ST_VBLANK] = 1'b0;
				end
			end
			dlts_pkg::KIND_WRITE: begin
				status_n = {item.write_value[dlts_pkg::STATUS_W-1:dlts_pkg::ST_RO_W],
					status_q[dlts_pkg::ST_RO_W-1:0]};
			end
			default: begin
			end
		endcase
		result.status = status_n;
		result.line   = line_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q           <= '0;
			status_q         <= '0;
			skip_q           <= '0;
			frames_to_skip_q <= '0;
		end else begin
			if (cfg_we) begin
				frames_to_skip_q <= cfg_skip;
			end
			if (advance) begin
				line_q   <= line_n;
				status_q <= status_n;
				skip_q   <= skip_n;
			end
		end
	end

endmodule

[rtl/dlts_out_stage.sv]
// ---------------------------------------------------------------------------
// Result stage
// Holds one finished result transaction until the downstream side takes it.
// ---------------------------------------------------------------------------
module dlts_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	input  dlts_pkg::result_t result_s1,
	output logic              advance,
	output logic              out_valid,
	input  logic              out_ready,
	output dlts_pkg::result_t result_s2
);

	assign advance = valid_s1 && (!out_valid || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_s1;
		end
	end

endmodule
